// ===== sv/ghbl_pkg.sv =====
// Shared types and constants for the grid height bilinear lookup.
// Holds register codes, the configuration bundle and the front-to-back queue entry.
// No dependencies.
package ghbl_pkg;

  // Widest row or column index over the whole parameter range (4096 cells).
  localparam int IDX_W  = 12;
  localparam int FRAC_W = 16;
  localparam int HGT_W  = 24;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_INV_STEP_X  = 3'd2,
    CFG_INV_STEP_Y  = 3'd3,
    CFG_GRID_WIDTH  = 3'd4,
    CFG_GRID_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic        [31:0] inv_step_x;
    logic signed [31:0] inv_step_y;
    logic        [9:0]  grid_width;
    logic        [9:0]  grid_height;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic                    wen;
    logic                    ok;
    logic [IDX_W-1:0]        row0;
    logic [IDX_W-1:0]        row1;
    logic [IDX_W-1:0]        col0;
    logic [IDX_W-1:0]        col1;
    logic [FRAC_W-1:0]       fx;
    logic [FRAC_W-1:0]       fy;
    logic signed [HGT_W-1:0] height;
  } entry_t;

endpackage

// ===== sv/ghbl_front.sv =====
// Front pipeline: maps query coordinates onto the grid and splits write indexes.
// Four stages; freezes while the queue is full. Depends on ghbl_pkg.
module ghbl_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  ghbl_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic                opcode,
  input  logic [17:0]         cell_index,
  input  logic signed [23:0]  height_in,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic                full,
  output logic                push,
  output ghbl_pkg::entry_t    entry
);

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam logic [29:0] RECIP = 30'((64'd1 << 30) / MAX_WIDTH);
  localparam logic [31:0] DEPTH = 32'(MAX_WIDTH * MAX_HEIGHT);
  localparam logic [XW-1:0] MAX_X = XW'(MAX_WIDTH);
  localparam logic [YW-1:0] MAX_Y = YW'(MAX_HEIGHT);

  logic adv;
  assign adv = !full;

  // stage 1: offsets from origin
  logic [32:0] dx, dy;
  assign dx = {coord_x[31], coord_x} - {cfg.origin_x[31], cfg.origin_x};
  assign dy = {coord_y[31], coord_y} - {cfg.origin_y[31], cfg.origin_y};

  logic        v1, op1, negx1, negy1, wen1;
  logic [32:0] magx1, magy1;
  logic [47:0] idxp1;
  logic [17:0] idx1;
  logic [23:0] hgt1;

  // stage 2: partial products
  logic [31:0] ymag;
  logic        ysneg;
  assign ysneg = cfg.inv_step_y[31];
  assign ymag  = ysneg ? (~cfg.inv_step_y + 32'd1) : cfg.inv_step_y;

  logic        v2, op2, negx2, negy2, wen2;
  logic [48:0] ppxl2, ppxh2, ppyl2, ppyh2;
  logic [17:0] q2, idx2;
  logic [23:0] hgt2;

  // stage 3: full products, write remainder
  logic        v3, op3, negx3, negy3, wen3;
  logic [64:0] prx3, pry3;
  logic [17:0] q3;
  logic [18:0] rem3;
  logic [23:0] hgt3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      op1   <= opcode;
      negx1 <= dx[32];
      negy1 <= dy[32];
      magx1 <= dx[32] ? (~dx + 33'd1) : dx;
      magy1 <= dy[32] ? (~dy + 33'd1) : dy;
      idxp1 <= 48'(cell_index) * 48'(RECIP);
      idx1  <= cell_index;
      wen1  <= {14'b0, cell_index} < DEPTH;
      hgt1  <= height_in;

      op2   <= op1;
      negx2 <= negx1;
      negy2 <= negy1;
      ppxl2 <= 49'(magx1) * 49'(cfg.inv_step_x[15:0]);
      ppxh2 <= 49'(magx1) * 49'(cfg.inv_step_x[31:16]);
      ppyl2 <= 49'(magy1) * 49'(ymag[15:0]);
      ppyh2 <= 49'(magy1) * 49'(ymag[31:16]);
      q2    <= idxp1[47:30];
      idx2  <= idx1;
      wen2  <= wen1;
      hgt2  <= hgt1;

      op3   <= op2;
      negx3 <= negx2;
      negy3 <= negy2;
      prx3  <= {16'b0, ppxl2} + {ppxh2, 16'b0};
      pry3  <= {16'b0, ppyl2} + {ppyh2, 16'b0};
      q3    <= q2;
      rem3  <= 19'({1'b0, idx2} - 19'(32'(q2) * 32'(MAX_WIDTH)));
      wen3  <= wen2;
      hgt3  <= hgt2;
    end
  end

  // stage 4: classify and build the queue entry
  logic [XW-1:0] extx, emx, ipxs, lox, hix;
  logic [YW-1:0] exty, emy, ipys, loy, hiy;
  logic [40:0]   ipx, ipy;
  logic [15:0]   frx, fry;
  logic          okx, oky, ge;
  logic [17:0]   roww, colw;
  ghbl_pkg::entry_t e;

  always_comb begin
    extx = ({3'b0, cfg.grid_width} > 13'(MAX_WIDTH)) ? MAX_X : XW'(cfg.grid_width);
    exty = ({3'b0, cfg.grid_height} > 13'(MAX_HEIGHT)) ? MAX_Y : YW'(cfg.grid_height);
    ipx  = prx3[64:24];
    ipy  = pry3[64:24];
    frx  = prx3[23:8];
    fry  = pry3[23:8];
    okx  = (extx != '0) && !(prx3 != '0 && negx3)
           && !(ipx > 41'(extx) || (ipx == 41'(extx) && frx != '0));
    oky  = (exty != '0) && !(pry3 != '0 && (negy3 != ysneg))
           && !(ipy > 41'(exty) || (ipy == 41'(exty) && fry != '0));
    emx  = extx - XW'(1);
    emy  = exty - YW'(1);
    ipxs = ipx[XW-1:0];
    ipys = ipy[YW-1:0];
    lox  = (ipxs >= emx) ? emx : ipxs;
    hix  = (({1'b0, ipxs} + (XW+1)'(1)) >= {1'b0, emx}) ? emx : ipxs + XW'(1);
    loy  = (ipys >= emy) ? emy : ipys;
    hiy  = (({1'b0, ipys} + (YW+1)'(1)) >= {1'b0, emy}) ? emy : ipys + YW'(1);

    ge   = rem3 >= 19'(MAX_WIDTH);
    roww = q3 + 18'(ge);
    colw = ge ? 18'(rem3 - 19'(MAX_WIDTH)) : 18'(rem3);

    e        = '0;
    e.op     = ghbl_pkg::op_t'(op3);
    e.wen    = wen3;
    e.ok     = okx && oky;
    e.fx     = frx;
    e.fy     = fry;
    e.height = hgt3;
    if (e.op == ghbl_pkg::OP_WRITE) begin
      if (wen3) begin
        e.row0 = ghbl_pkg::IDX_W'(roww);
        e.row1 = ghbl_pkg::IDX_W'(roww);
        e.col0 = ghbl_pkg::IDX_W'(colw);
        e.col1 = ghbl_pkg::IDX_W'(colw);
      end
    end else if (okx && oky) begin
      e.row0 = ghbl_pkg::IDX_W'(loy);
      e.row1 = ghbl_pkg::IDX_W'(hiy);
      e.col0 = ghbl_pkg::IDX_W'(lox);
      e.col1 = ghbl_pkg::IDX_W'(hix);
    end
  end

  logic v4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      entry <= e;
    end
  end

  assign push = v4 && adv;

endmodule

// ===== sv/ghbl_fifo.sv =====
// Short queue of transactions between the front and back pipelines.
// Depends on ghbl_pkg for the entry type.
module ghbl_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ghbl_pkg::entry_t din,
  input  logic             pop,
  output ghbl_pkg::entry_t dout,
  output logic             empty,
  output logic             full
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  ghbl_pkg::entry_t    slots [DEPTH];
  logic [PW-1:0]       wptr, rptr;
  logic [PW:0]         count;
  logic                do_pop;

  assign empty  = (count == '0);
  assign full   = (count == (PW+1)'(DEPTH));
  assign do_pop = pop && !empty;
  assign dout   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (do_pop) rptr <= rptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(do_pop);
    end
    if (push) slots[wptr] <= din;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH)) else $error("queue count overflow");
`endif

endmodule

// ===== sv/ghbl_back.sv =====
// Back pipeline: four interleaved height banks and the bilinear blend.
// Takes one queued transaction per cycle. Depends on ghbl_pkg.
module ghbl_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  ghbl_pkg::entry_t    head,
  output logic                pop,
  output logic                done,
  output logic signed [23:0]  height_out,
  output logic                valid_res
);

  localparam int HW     = (MAX_WIDTH + 1) / 2;
  localparam int HH     = (MAX_HEIGHT + 1) / 2;
  localparam int BDEPTH = HW * HH;
  localparam int BA     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int IW     = ghbl_pkg::IDX_W;

  function automatic logic [BA-1:0] bank_addr(logic [IW-1:0] r, logic [IW-1:0] c);
    return BA'(32'(r >> 1) * 32'(HW) + 32'(c >> 1));
  endfunction

  assign pop = head_valid;

  logic        is_query;
  logic [1:0]  wbank;
  logic [BA-1:0] waddr;
  logic [23:0] rd [4];

  assign is_query = head_valid && (head.op == ghbl_pkg::OP_QUERY);
  assign wbank    = {head.row0[0], head.col0[0]};
  assign waddr    = bank_addr(head.row0, head.col0);

  // bank {row parity, column parity}; each bank sees exactly one neighbour row/column
  genvar b;
  for (b = 0; b < 4; b++) begin : g_bank
    logic [23:0]   mem [BDEPTH];
    logic [IW-1:0] r, c;
    logic          we;
    assign r  = (head.row0[0] == 1'(b / 2)) ? head.row0 : head.row1;
    assign c  = (head.col0[0] == 1'(b % 2)) ? head.col0 : head.col1;
    assign we = head_valid && (head.op == ghbl_pkg::OP_WRITE) && head.wen
                && (wbank == 2'(b));
    always_ff @(posedge clk) begin
      if (we) mem[waddr] <= head.height;
      rd[b] <= mem[bank_addr(r, c)];
    end
  end

  logic        v1, ok1, py0, py1, px0, px1;
  logic [15:0] fx1, fy1;

  logic signed [23:0] h00, h01, h10, h11;
  logic signed [24:0] dxt, dxb;
  logic signed [41:0] topc, botc;
  assign h00  = rd[{py0, px0}];
  assign h01  = rd[{py0, px1}];
  assign h10  = rd[{py1, px0}];
  assign h11  = rd[{py1, px1}];
  assign dxt  = 25'(h01) - 25'(h00);
  assign dxb  = 25'(h11) - 25'(h10);
  assign topc = {{2{h00[23]}}, h00, 16'b0} + 42'(dxt) * 42'($signed({1'b0, fx1}));
  assign botc = {{2{h10[23]}}, h10, 16'b0} + 42'(dxb) * 42'($signed({1'b0, fx1}));

  logic               v2, ok2;
  logic [15:0]        fy2;
  logic signed [41:0] top2, bot2;
  logic signed [42:0] dy;
  assign dy = 43'(bot2) - 43'(top2);

  logic               v3, ok3;
  logic signed [41:0] top3;
  logic        [37:0] pplo3;
  logic signed [37:0] pphi3;
  logic signed [59:0] sum;
  assign sum = {{2{top3[41]}}, top3, 16'b0} + {22'b0, pplo3}
             + {pphi3, 22'b0} + 60'sh80000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= is_query;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
    ok1  <= head.ok;
    fx1  <= head.fx;
    fy1  <= head.fy;
    py0  <= head.row0[0];
    py1  <= head.row1[0];
    px0  <= head.col0[0];
    px1  <= head.col1[0];

    ok2  <= ok1;
    fy2  <= fy1;
    top2 <= topc;
    bot2 <= botc;

    ok3   <= ok2;
    top3  <= top2;
    pplo3 <= 38'(dy[21:0]) * 38'(fy2);
    pphi3 <= 38'($signed(dy[42:22])) * 38'($signed({1'b0, fy2}));

    valid_res  <= ok3;
    height_out <= ok3 ? sum[55:32] : 24'sd0;
  end

`ifndef SYNTHESIS
  a_done_follows_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(is_query, 4)) else $error("result without a query");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (height_out == 24'sd0)) else $error("invalid result not zero");
`endif

endmodule

// ===== sv/grid_height_bilinear_lookup.sv =====
// Top level of the grid height bilinear lookup: configuration registers,
// front pipeline, queue and back pipeline. Depends on ghbl_pkg and the ghbl_* modules.
//
// Use:
//  - Input channel: a transaction is taken at a rising edge with start high and busy
//    low. opcode selects a cell write (cell_index, height_in) or a point query
//    (coord_x, coord_y, Q24.8 map units).
//  - Result channel: each query yields one result, shown for one cycle with done
//    high; height_out is Q16.8 and valid_res is low (with height_out zero) when the
//    point falls outside the grid. Writes yield nothing. The receiver cannot stall.
//  - Configuration channel: cfg_index/cfg_data written when cfg_valid and cfg_ready
//    are high; cfg_ready is always high. Write only while no query is in flight.
//  - Throughput: one transaction per cycle while busy is low, set by the four banks that
//    hold even/odd rows and columns so all four neighbours are read in the same cycle.
//  - Path: a query passes the four front stages, the queue, the bank read and three
//    blend stages before done rises.
//  - Reset clears control state and registers to their defaults; grid cells hold
//    nothing defined until written. busy rises only if the queue fills.
module grid_height_bilinear_lookup #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [17:0]        cell_index,
  input  logic signed [23:0] height_in,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [23:0] height_out,
  output logic               valid_res
);

  ghbl_pkg::cfg_t   cfg;
  ghbl_pkg::entry_t f_entry, q_head;
  logic             push, pop, q_empty, q_full, accept;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !busy;

  // Hold configuration; drop writes to indexes past the last register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= 32'sd0;
      cfg.origin_y    <= 32'sd0;
      cfg.inv_step_x  <= 32'd65536;
      cfg.inv_step_y  <= -32'sd65536;
      cfg.grid_width  <= 10'd512;
      cfg.grid_height <= 10'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (ghbl_pkg::cfg_idx_t'(cfg_index))
        ghbl_pkg::CFG_ORIGIN_X:    cfg.origin_x    <= cfg_data;
        ghbl_pkg::CFG_ORIGIN_Y:    cfg.origin_y    <= cfg_data;
        ghbl_pkg::CFG_INV_STEP_X:  cfg.inv_step_x  <= cfg_data;
        ghbl_pkg::CFG_INV_STEP_Y:  cfg.inv_step_y  <= cfg_data;
        ghbl_pkg::CFG_GRID_WIDTH:  cfg.grid_width  <= cfg_data[9:0];
        ghbl_pkg::CFG_GRID_HEIGHT: cfg.grid_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Map and classify each transaction; advance only while the queue has room.
  ghbl_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .opcode     (opcode),
    .cell_index (cell_index),
    .height_in  (height_in),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .full       (q_full),
    .push       (push),
    .entry      (f_entry)
  );

  // Keep writes and queries in one queue so reads see every earlier write.
  ghbl_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_entry),
    .pop   (pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  ghbl_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head       (q_head),
    .pop        (pop),
    .done       (done),
    .height_out (height_out),
    .valid_res  (valid_res)
  );

`ifndef SYNTHESIS
  a_busy_only_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop || push == 1'b0) else $error("busy with queue moving");
`endif

endmodule
